>>> design/annexb_pkg.sv
// Shared types and constants for the Annex B to length-prefixed NAL rewriter.
// Used by the front classifier, the command queue, the back unit and the top level.
// No dependencies.
package annexb_pkg;

    // Fixed widths of the channel fields.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 24;
    localparam int VALUE_W = 25;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 4;

    // One classified input byte: the list of operations the back unit runs,
    // in this order: held zeros, data byte, close plus open, open alone,
    // zeros flushed at packet end, closing length word, done.
    typedef struct packed {
        logic [1:0]        zeros_pre;
        logic              data_en;
        logic [BYTE_W-1:0] data;
        logic              close_en;
        logic              open_en;
        logic [1:0]        zeros_post;
        logic              close_end;
        logic              done;
    } cmd_t;

endpackage

>>> design/annexb_to_length_prefixed_nal.sv
// Top level of the Annex B to length-prefixed NAL rewriter.
// Instantiates annexb_front, annexb_cmd_fifo and annexb_back; uses annexb_pkg.
//
//   Channel   Handshake                    Fields
//   input     byte_valid / byte_ready      data_byte, end_of_packet
//   result    result_valid / result_ready  kind, address, value, overflow, last_of_run
//
// An input byte is taken whenever the command queue has room.
// The back unit runs one operation for each result; a byte causes zero to six results,
// and the start code that opens a packet's first NAL runs an operation with no result.
// A byte's command is registered in the queue, its first result in the result stage.
// A four-entry command queue absorbs bursts; while a result waits for result_ready
// the back unit stalls, and the queue keeps taking bytes until it fills.
// Reset returns the block to searching for a start code at output address zero.
module annexb_to_length_prefixed_nal
#(
    parameter int ADDR_BITS = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    output logic                           byte_ready,
    input  logic [annexb_pkg::BYTE_W-1:0]  data_byte,
    input  logic                           end_of_packet,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [annexb_pkg::KIND_W-1:0]  kind,
    output logic [annexb_pkg::ADDR_W-1:0]  address,
    output logic [annexb_pkg::VALUE_W-1:0] value,
    output logic                           overflow,
    output logic                           last_of_run
);
    import annexb_pkg::*;

    logic accept;
    logic cmd_push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t head;
    logic empty;

    // An input transfer needs a free queue entry.
    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;

    annexb_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .cmd_push      (cmd_push),
        .cmd           (push_cmd)
    );

    annexb_cmd_fifo u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    annexb_back #(.ADDR_BITS(ADDR_BITS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .address      (address),
        .value        (value),
        .overflow     (overflow),
        .last_of_run  (last_of_run)
    );

endmodule

>>> design/annexb_front.sv
// Front classifier: tracks start-code search and held zeros per input byte.
// Turns each accepted byte into a command for the back unit.
// Depends on annexb_pkg.
module annexb_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [annexb_pkg::BYTE_W-1:0] data_byte,
    input  logic                       end_of_packet,
    output logic                       cmd_push,
    output annexb_pkg::cmd_t           cmd
);
    import annexb_pkg::*;

    logic       in_nal_reg;
    logic       in_nal_next;
    logic [1:0] held_reg;
    logic [1:0] held_next;

    // Classify the byte and derive the next search state.
    always_comb
    begin
        logic is_zero;
        logic is_start;
        logic any_op;
        is_zero  = (data_byte == '0);
        is_start = (data_byte == BYTE_W'(1)) && (held_reg >= 2'd2);

        cmd         = '0;
        in_nal_next = in_nal_reg;
        held_next   = held_reg;

        if (!in_nal_reg)
        begin
            if (is_zero)
            begin
                if (held_reg != 2'd3)
                begin
                    held_next = held_reg + 2'd1;
                end
            end
            else if (is_start)
            begin
                cmd.open_en = 1'b1;
                in_nal_next = 1'b1;
                held_next   = 2'd0;
            end
            else
            begin
                held_next = 2'd0;
            end
        end
        else
        begin
            if (is_zero)
            begin
                // A fourth zero pushes the oldest held one out as data.
                if (held_reg == 2'd3)
                begin
                    cmd.data_en = 1'b1;
                    cmd.data    = '0;
                end
                else
                begin
                    held_next = held_reg + 2'd1;
                end
            end
            else if (is_start)
            begin
                cmd.close_en = 1'b1;
                cmd.open_en  = 1'b1;
                held_next    = 2'd0;
            end
            else
            begin
                cmd.zeros_pre = held_reg;
                cmd.data_en   = 1'b1;
                cmd.data      = data_byte;
                held_next     = 2'd0;
            end
        end

        // Packet end flushes held zeros, closes an open NAL and reports the size.
        if (end_of_packet)
        begin
            if (in_nal_next)
            begin
                cmd.zeros_post = held_next;
                cmd.close_end  = 1'b1;
            end
            cmd.done    = 1'b1;
            in_nal_next = 1'b0;
            held_next   = 2'd0;
        end

        any_op = (cmd.zeros_pre != 2'd0) || cmd.data_en || cmd.close_en || cmd.open_en
              || (cmd.zeros_post != 2'd0) || cmd.close_end || cmd.done;
        cmd_push = accept && any_op;
    end

    // Search state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_nal_reg <= 1'b0;
            held_reg   <= 2'd0;
        end
        else if (accept)
        begin
            in_nal_reg <= in_nal_next;
            held_reg   <= held_next;
        end
    end

endmodule

>>> design/annexb_cmd_fifo.sv
// Short command queue between the front classifier and the back unit.
// Registers only; the head entry is read combinationally.
// Depends on annexb_pkg.
module annexb_cmd_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  annexb_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output annexb_pkg::cmd_t head,
    output logic             empty
);
    import annexb_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             entry_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(CMD_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Occupancy follows the push and pop transfers.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/annexb_back.sv
// Back unit: runs queued commands one operation per cycle while the result stage is free or
// being emptied, keeps the output byte space pointers and drives the registered result stage.
// Depends on annexb_pkg.
module annexb_back
#(
    parameter int ADDR_BITS = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  annexb_pkg::cmd_t               head,
    input  logic                           empty,
    output logic                           pop,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [annexb_pkg::KIND_W-1:0]  kind,
    output logic [annexb_pkg::ADDR_W-1:0]  address,
    output logic [annexb_pkg::VALUE_W-1:0] value,
    output logic                           overflow,
    output logic                           last_of_run
);
    import annexb_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam logic [AW:0]   CAP    = {1'b1, AW'(0)};
    localparam logic [AW-1:0] CAP_M1 = {AW{1'b1}};

    // Operation codes.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_OPEN  = 2'd2;
    localparam logic [1:0] OP_DONE  = 2'd3;

    cmd_t          cur_reg;
    cmd_t          cur_next;
    logic          cur_valid_reg;
    logic          cur_valid_next;
    logic [AW:0]   wp_reg;
    logic [AW:0]   wp_next;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] slot_next;
    logic [AW:0]   nal_len_reg;
    logic [AW:0]   nal_len_next;
    logic          ovf_reg;
    logic          ovf_next;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [ADDR_W-1:0]  address_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               ovf_out_reg;
    logic               last_reg;

    cmd_t          eff;
    cmd_t          rem;
    logic          have_cmd;
    logic          step;
    logic [1:0]    op;
    logic          open_too;
    logic [BYTE_W-1:0] put_byte;
    logic          emit;
    logic [KIND_W-1:0] emit_kind;
    logic [AW-1:0] emit_addr;
    logic [AW:0]   emit_val;
    logic          emit_ovf;
    logic          more;

    // Pick the next pending operation of the current command.
    always_comb
    begin
        eff      = cur_valid_reg ? cur_reg : head;
        have_cmd = cur_valid_reg || !empty;
        step     = have_cmd && (!res_valid_reg || result_ready);
        rem      = eff;
        open_too = 1'b0;
        put_byte = '0;
        op       = OP_DONE;
        if (eff.zeros_pre != 2'd0)
        begin
            op            = OP_PUT;
            rem.zeros_pre = eff.zeros_pre - 2'd1;
        end
        else if (eff.data_en)
        begin
            op          = OP_PUT;
            put_byte    = eff.data;
            rem.data_en = 1'b0;
        end
        else if (eff.close_en)
        begin
            op           = OP_CLOSE;
            open_too     = eff.open_en;
            rem.close_en = 1'b0;
            rem.open_en  = 1'b0;
        end
        else if (eff.open_en)
        begin
            op          = OP_OPEN;
            rem.open_en = 1'b0;
        end
        else if (eff.zeros_post != 2'd0)
        begin
            op             = OP_PUT;
            rem.zeros_post = eff.zeros_post - 2'd1;
        end
        else if (eff.close_end)
        begin
            op            = OP_CLOSE;
            rem.close_end = 1'b0;
        end
        else
        begin
            op       = OP_DONE;
            rem.done = 1'b0;
        end
        more = (rem.zeros_pre != 2'd0) || rem.data_en || rem.close_en
            || (rem.zeros_post != 2'd0) || rem.close_end || rem.done;
        pop            = step && !cur_valid_reg;
        cur_next       = step ? rem : cur_reg;
        cur_valid_next = step ? (more || rem.open_en) : cur_valid_reg;
    end

    // Execute the chosen operation on the byte space state.
    always_comb
    begin
        logic [AW+1:0] wp_plus4;
        wp_plus4     = {1'b0, wp_reg} + (AW+2)'(4);
        wp_next      = wp_reg;
        slot_next    = slot_reg;
        nal_len_next = nal_len_reg;
        ovf_next     = ovf_reg;
        emit         = 1'b0;
        emit_kind    = KIND_DATA;
        emit_addr    = '0;
        emit_val     = '0;
        emit_ovf     = ovf_reg;

        case (op)
            OP_PUT:
            begin
                // Addresses saturate at the top of the byte space.
                if (wp_reg[AW])
                begin
                    ovf_next  = 1'b1;
                    emit_addr = CAP_M1;
                end
                else
                begin
                    emit_addr = wp_reg[AW-1:0];
                    wp_next   = wp_reg + (AW+1)'(1);
                end
                if (!nal_len_reg[AW])
                begin
                    nal_len_next = nal_len_reg + (AW+1)'(1);
                end
                emit      = 1'b1;
                emit_kind = KIND_DATA;
                emit_val  = (AW+1)'(put_byte);
                emit_ovf  = ovf_next;
            end
            OP_CLOSE, OP_OPEN:
            begin
                if (op == OP_CLOSE)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_LENGTH;
                    emit_addr = slot_reg;
                    emit_val  = nal_len_reg;
                    emit_ovf  = ovf_reg;
                end
                // Reserve the four-byte length slot of the next NAL.
                if (op == OP_OPEN || open_too)
                begin
                    if (wp_plus4 > {1'b0, CAP})
                    begin
                        ovf_next = 1'b1;
                    end
                    slot_next    = wp_reg[AW] ? CAP_M1 : wp_reg[AW-1:0];
                    wp_next      = (wp_plus4 < {1'b0, CAP}) ? wp_plus4[AW:0] : CAP;
                    nal_len_next = '0;
                end
            end
            default:
            begin
                // Packet done: report the size, then clear the packet state.
                emit         = 1'b1;
                emit_kind    = KIND_DONE;
                emit_addr    = '0;
                emit_val     = wp_reg;
                emit_ovf     = ovf_reg;
                wp_next      = '0;
                slot_next    = '0;
                nal_len_next = '0;
                ovf_next     = 1'b0;
            end
        endcase
    end

    // Result stage occupancy.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (step && emit)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Control and pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            wp_reg        <= '0;
            slot_reg      <= '0;
            nal_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            res_valid_reg <= res_valid_next;
            if (step)
            begin
                wp_reg      <= wp_next;
                slot_reg    <= slot_next;
                nal_len_reg <= nal_len_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    // Payload registers: working command and result fields.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (step && emit)
        begin
            kind_reg    <= emit_kind;
            address_reg <= ADDR_W'(emit_addr);
            value_reg   <= VALUE_W'(emit_val);
            ovf_out_reg <= emit_ovf;
            last_reg    <= !more;
        end
    end

    assign result_valid = res_valid_reg;
    assign kind         = kind_reg;
    assign address      = address_reg;
    assign value        = value_reg;
    assign overflow     = ovf_out_reg;
    assign last_of_run  = last_reg;

    // The write pointer and the NAL length never pass capacity.
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= CAP) else $error("write pointer beyond capacity");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nal_len_reg <= CAP) else $error("NAL length beyond capacity");
    // While the write pointer is nonzero, the open length slot lies below it.
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg != '0 |-> {1'b0, slot_reg} < wp_reg) else $error("length slot not below pointer");
    // A done operation leaves the byte space state cleared.
    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && op == OP_DONE |=> wp_reg == '0 && !ovf_reg) else $error("packet state not cleared");

endmodule

>>> bench/annexb_nal_checker.sv
`timescale 1ns / 1ps
// Result checker for the Annex B to length-prefixed NAL rewriter.
// Watches both channels, predicts the results of every accepted byte and compares them.
// Depends on annexb_pkg for field widths and result kinds.
module annexb_nal_checker
#(
    parameter int ADDR_BITS = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    input  logic                           byte_ready,
    input  logic [annexb_pkg::BYTE_W-1:0]  data_byte,
    input  logic                           end_of_packet,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  logic [annexb_pkg::KIND_W-1:0]  kind,
    input  logic [annexb_pkg::ADDR_W-1:0]  address,
    input  logic [annexb_pkg::VALUE_W-1:0] value,
    input  logic                           overflow,
    input  logic                           last_of_run,
    output int                             failures,
    output int                             outstanding
);
    import annexb_pkg::*;

    localparam longint unsigned CAP = 64'd1 << ADDR_BITS;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  address;
        logic [VALUE_W-1:0] value;
        logic               overflow;
        logic               last;
    } nal_result_t;

    // Results still owed by the block, oldest first, and those of the byte in hand.
    nal_result_t expected_results[$];
    nal_result_t byte_results[$];
    nal_result_t seen_want;

    // Rewriter state as the block should hold it.
    bit                 in_nal;
    bit [1:0]           zeros_held;
    bit [ADDR_BITS:0]   wr_ptr;
    bit [ADDR_BITS-1:0] slot_addr;
    bit [ADDR_BITS:0]   nal_len;
    bit                 ovf_seen;

    function automatic void clear_packet();
        in_nal     = 1'b0;
        zeros_held = '0;
        wr_ptr     = '0;
        slot_addr  = '0;
        nal_len    = '0;
        ovf_seen   = 1'b0;
    endfunction

    function automatic void add_result(logic [KIND_W-1:0] k, longint unsigned a,
                                       longint unsigned v);
        nal_result_t r;
        r.kind     = k;
        r.address  = a[ADDR_W-1:0];
        r.value    = v[VALUE_W-1:0];
        r.overflow = ovf_seen;
        r.last     = 1'b0;
        byte_results.insert(byte_results.size(), r);
    endfunction

    // One data byte at the write pointer; past capacity the address sticks at the top.
    function automatic void write_byte(logic [BYTE_W-1:0] b);
        longint unsigned a;
        if (wr_ptr >= CAP) begin
            ovf_seen = 1'b1;
            a = CAP - 1;
        end
        else begin
            a = wr_ptr;
            wr_ptr = wr_ptr + 1'b1;
        end
        if (nal_len < CAP)
            nal_len = nal_len + 1'b1;
        add_result(KIND_DATA, a, b);
    endfunction

    function automatic void release_zeros();
        while (zeros_held > 0) begin
            write_byte('0);
            zeros_held = zeros_held - 1'b1;
        end
    endfunction

    // Reserve the four-byte length slot of a new NAL unit.
    function automatic void start_nal();
        if (wr_ptr + 4 > CAP)
            ovf_seen = 1'b1;
        slot_addr  = ADDR_BITS'((wr_ptr < CAP) ? wr_ptr : CAP - 1);
        wr_ptr     = (ADDR_BITS+1)'((wr_ptr + 4 < CAP) ? wr_ptr + 4 : CAP);
        nal_len    = '0;
        in_nal     = 1'b1;
        zeros_held = '0;
    endfunction

    function automatic void end_nal();
        add_result(KIND_LENGTH, slot_addr, nal_len);
    endfunction

    // Work out every result caused by one input byte and queue them.
    function automatic void predict_byte(logic [BYTE_W-1:0] b, logic eop);
        byte_results.delete();
        if (!in_nal) begin
            if (b == 8'h00) begin
                if (zeros_held < 3)
                    zeros_held = zeros_held + 1'b1;
            end
            else if (b == 8'h01 && zeros_held >= 2)
                start_nal();
            else
                zeros_held = '0;
        end
        else begin
            if (b == 8'h00) begin
                if (zeros_held >= 3)
                    write_byte('0);
                else
                    zeros_held = zeros_held + 1'b1;
            end
            else if (b == 8'h01 && zeros_held >= 2) begin
                end_nal();
                start_nal();
            end
            else begin
                release_zeros();
                write_byte(b);
            end
        end

        // Packet end: flush, close the open NAL unit, report the size.
        if (eop) begin
            if (in_nal) begin
                release_zeros();
                end_nal();
            end
            add_result(KIND_DONE, 0, (wr_ptr < CAP) ? wr_ptr : CAP);
            clear_packet();
        end

        if (byte_results.size() > 0)
            byte_results[byte_results.size()-1].last = 1'b1;
        foreach (byte_results[i])
            expected_results.insert(expected_results.size(), byte_results[i]);
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            failures++;
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
    endfunction

    // Prediction on input transfers, comparison on result transfers.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_packet();
            expected_results.delete();
        end
        else begin
            if (byte_valid && byte_ready)
                predict_byte(data_byte, end_of_packet);
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    failures++;
                    $error("unexpected result: kind %0d, address %0d, value %0d",
                           kind, address, value);
                end
                else begin
                    seen_want = expected_results.pop_front();
                    check_field("kind", seen_want.kind, kind);
                    check_field("address", seen_want.address, address);
                    check_field("value", seen_want.value, value);
                    check_field("overflow", seen_want.overflow, overflow);
                    check_field("last_of_run", seen_want.last, last_of_run);
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> bench/annexb_to_length_prefixed_nal_test.sv
`timescale 1ns / 1ps
// Top of the testbench for annexb_to_length_prefixed_nal: clock, reset, byte stimulus,
// result back-pressure and the verdict. Depends on annexb_pkg and annexb_nal_checker.
module annexb_to_length_prefixed_nal_test;
    import annexb_pkg::*;

    // A narrow address space for the block under test.
    localparam int ADDR_BITS    = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int ITEM_COUNT   = 130;

    logic               clk;
    logic               rst_n;
    logic               byte_valid;
    logic               byte_ready;
    logic [BYTE_W-1:0]  data_byte;
    logic               end_of_packet;
    logic               result_valid;
    logic               result_ready;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;
    logic [VALUE_W-1:0] value;
    logic               overflow;
    logic               last_of_run;

    int failures;
    int outstanding;
    int cycle_count;
    int items_sent;

    // Shared between the sender and the receiver.
    bit quiet_phase;
    bit hold_request;

    logic [7:0] pkt[$];

    annexb_to_length_prefixed_nal #(.ADDR_BITS(ADDR_BITS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .address       (address),
        .value         (value),
        .overflow      (overflow),
        .last_of_run   (last_of_run)
    );

    annexb_nal_checker #(.ADDR_BITS(ADDR_BITS)) nal_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .address       (address),
        .value         (value),
        .overflow      (overflow),
        .last_of_run   (last_of_run),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short idle gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Payload bytes lean on zeros, 01 and the extremes to provoke start codes.
    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 8'h00;
        else if (r < 35)
            return 8'h01;
        else if (r < 40)
            return 8'hFF;
        else if (r < 45)
            return 8'h80;
        return 8'($urandom_range(0, 255));
    endfunction

    // Append one byte to the packet being built.
    function automatic void add_pkt_byte(logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endfunction

    // A packet of start codes and NAL units, some of them empty or broken.
    function automatic void build_nal_packet();
        int zeros;
        int r;
        pkt.delete();
        repeat ($urandom_range(0, 2))
            add_pkt_byte(payload_byte());
        repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 99);
            zeros = (r < 10) ? 1 : (r < 50) ? 2 : (r < 88) ? 3 : $urandom_range(4, 5);
            repeat (zeros)
                add_pkt_byte(8'h00);
            add_pkt_byte(8'h01);
            repeat ($urandom_range(0, 8))
                add_pkt_byte(payload_byte());
        end
        r = $urandom_range(0, 99);
        if (r < 20) begin
            repeat ($urandom_range(1, 3))
                add_pkt_byte(8'h00);
        end
        else if (r < 30) begin
            add_pkt_byte(8'h00);
            add_pkt_byte(8'h00);
            add_pkt_byte(8'h01);
        end
    endfunction

    function automatic void build_noise_packet();
        pkt.delete();
        repeat ($urandom_range(1, 8))
            add_pkt_byte(payload_byte());
    endfunction

    // One NAL unit of the given size with no zeros, so it cannot split.
    function automatic void push_plain_nal(int len);
        add_pkt_byte(8'h00);
        add_pkt_byte(8'h00);
        add_pkt_byte(8'h01);
        repeat (len)
            add_pkt_byte(8'($urandom_range(2, 255)));
    endfunction

    // Offer one byte and wait for its transfer; called and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic eop);
        int gap;
        gap = quiet_phase ? 0 : pick_gap();
        if (gap > 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid    <= 1'b1;
        data_byte     <= b;
        end_of_packet <= eop;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_packet();
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
        items_sent += pkt.size();
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else begin
                gap = quiet_phase ? 0 : pick_gap();
                if (gap == 0)
                    result_ready <= 1'b1;
                else begin
                    result_ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    // Run limit in case the block hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("annexb_to_length_prefixed_nal verification failed");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int packet_no;
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        data_byte     = '0;
        end_of_packet = 1'b0;
        quiet_phase   = 1'b0;
        hold_request  = 1'b0;
        items_sent    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Junk before the first start code, four zeros inside a NAL unit ahead of a
        // start code, back-to-back start codes, and a start code on the final byte.
        pkt = '{8'h55, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h01};
        send_packet();
        // No start code at all.
        pkt = '{8'h12, 8'h00, 8'h02};
        send_packet();
        // Long zero run while searching, then a held zero flushed at packet end.
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
        send_packet();

        // Random packets, one of them under a long receiver hold-off that
        // fills the block and stalls the input.
        packet_no = 0;
        while (items_sent < ITEM_COUNT) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            if (packet_no == 1) begin
                pkt.delete();
                push_plain_nal(20);
                quiet_phase  = 1'b1;
                hold_request = 1'b1;
            end
            else if ($urandom_range(0, 99) < 80)
                build_nal_packet();
            else
                build_noise_packet();
            send_packet();
            packet_no++;
        end
        byte_valid    <= 1'b0;
        end_of_packet <= 1'b0;

        // Drain, then wait for anything extra to show up.
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("annexb_to_length_prefixed_nal verification clean");
        else
            $display("annexb_to_length_prefixed_nal verification failed");
        $finish;
    end

endmodule
